>>> src/pdtx_pkg.sv
`timescale 1ns / 1ps
package pdtx_pkg;

	// transmit phases, encoded as reported on the tx_state field
	typedef enum logic [1:0] {
		ST_IDLE     = 2'd0,
		ST_PHY_DONE = 2'd1,
		ST_TXDONE   = 2'd2,
		ST_RESP     = 2'd3
	} tx_state_t;

	// policy engine request codes, other codes act as an ordinary message
	localparam logic [2:0] REQ_MSG     = 3'd0;
	localparam logic [2:0] REQ_SOFT    = 3'd1;
	localparam logic [2:0] REQ_HARD    = 3'd2;
	localparam logic [2:0] REQ_BIST    = 3'd3;
	localparam logic [2:0] REQ_READY   = 3'd4;
	localparam logic [2:0] REQ_HR_RCVD = 3'd5;

	// configuration register indexes
	localparam logic CFG_PD2_MODE    = 1'b0;
	localparam logic CFG_RETRY_COUNT = 1'b1;

	localparam logic [2:0] RETRY_COUNT_RST = 3'd3;
	localparam logic [7:0] NO_ID           = 8'hFF;

	// input event fields other than the request, last field in the lowest bits
	typedef struct packed {
		logic       bist_more;
		logic [2:0] goodcrc_message_id;
		logic       receive_timeout;
		logic       phy_sent;
	} ev_t;

	// result fields, last field in the lowest bits
	typedef struct packed {
		tx_state_t  tx_state;
		logic [7:0] stored_rx_id;
		logic [2:0] message_id;
		logic       layer_reset;
		logic       clear_timeout;
		logic       build_message;
		logic       message_sent;
		logic       notify_pe;
		logic       start_phy;
	} res_t;

	localparam int EV_W  = $bits(ev_t);
	localparam int RES_W = $bits(res_t);

endpackage

>>> src/pd_protocol_tx_retry_fsm.sv
`timescale 1ns / 1ps
// channel  | direction | signals                          | content
// s        | in        | s_tvalid s_tready s_tdata s_tuser | one transmit event
// m        | out       | m_tvalid m_tready m_tdata        | one result per event
// cfg      | in        | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// one event per cycle while the output is not stalled: the event is registered, decided by
// the state machine once the output register can take it, and its result lands there
// m_tvalid rises with the result in the output register, the m transfer follows at the earliest
// a stalled output holds the result; the input register still takes one more event
// arst_n clears the phase, the retry and MessageID counters and the valid flags; cfg returns to defaults
module pd_protocol_tx_retry_fsm (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	// phy_sent, receive_timeout, goodcrc_message_id[2:0], bist_more, zero pad
	input  logic [7:0] s_tdata,
	// pe_request[2:0]
	input  logic [2:0] s_tuser,
	output logic       m_tvalid,
	input  logic       m_tready,
	// start_phy, notify_pe, message_sent, build_message, clear_timeout,
	// layer_reset, message_id[2:0], stored_rx_id[7:0], tx_state[1:0], zero pad
	output logic [23:0] m_tdata,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [2:0] cfg_data
);
	import pdtx_pkg::*;

	logic       pd2_mode_q;
	logic [2:0] retry_count_q;

	logic       valid_s1;
	ev_t        ev_s1;
	logic [2:0] req_s1;
	logic       advance;

	tx_state_t  state_q, state_d;
	logic [2:0] retries_q, retries_d;
	logic [2:0] msg_id_q, msg_id_d;
	logic [2:0] limit;
	logic       crc_ok;

	res_t       res_d;
	res_t       res_q;
	logic       out_valid_q;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd2_mode_q    <= 1'b0;
			retry_count_q <= RETRY_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_PD2_MODE:    pd2_mode_q    <= cfg_data[0];
				CFG_RETRY_COUNT: retry_count_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// input register, refilled whenever its event moves on
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ev_s1  <= ev_t'(s_tdata[EV_W-1:0]);
			req_s1 <= s_tuser;
		end
	end

	// retry limit drops by one outside pd2, saturating at zero
	always_comb begin
		limit = retry_count_q;
		if (!pd2_mode_q && retry_count_q != 3'd0) begin
			limit = retry_count_q - 3'd1;
		end
	end

	assign crc_ok = ev_s1.phy_sent && !ev_s1.receive_timeout &&
		(ev_s1.goodcrc_message_id == msg_id_q);

	// next state and result for the registered event
	always_comb begin
		res_d     = '0;
		state_d   = state_q;
		retries_d = retries_q;
		msg_id_d  = msg_id_q;
		unique case (state_q)
			ST_IDLE: begin
				retries_d = 3'd0;
				if (req_s1 == REQ_SOFT) begin
					msg_id_d = 3'd0;
				end
				if (req_s1 != REQ_READY) begin
					res_d.build_message = 1'b1;
					res_d.start_phy     = 1'b1;
					if (req_s1 == REQ_HARD || req_s1 == REQ_BIST) begin
						state_d             = ST_PHY_DONE;
						res_d.clear_timeout = (req_s1 == REQ_BIST);
					end else begin
						state_d = ST_TXDONE;
					end
				end
			end
			ST_PHY_DONE: begin
				if (req_s1 == REQ_BIST) begin
					if (ev_s1.bist_more) begin
						res_d.start_phy = 1'b1;
					end else begin
						state_d         = ST_IDLE;
						res_d.notify_pe = 1'b1;
					end
				end else if (ev_s1.phy_sent) begin
					// hard reset sent: phy layer reset
					res_d.layer_reset   = 1'b1;
					res_d.clear_timeout = 1'b1;
					state_d             = ST_IDLE;
					msg_id_d            = 3'd0;
				end else begin
					res_d.start_phy = 1'b1;
				end
			end
			ST_TXDONE: begin
				res_d.clear_timeout = 1'b1;
				state_d             = ST_RESP;
			end
			ST_RESP: begin
				if (crc_ok) begin
					msg_id_d           = msg_id_q + 3'd1;
					res_d.notify_pe    = 1'b1;
					res_d.message_sent = 1'b1;
					state_d            = ST_IDLE;
				end else if (req_s1 == REQ_HR_RCVD) begin
					state_d = ST_IDLE;
				end else if (retries_q >= limit) begin
					// retries exhausted: skip the id and report failure
					msg_id_d        = msg_id_q + 3'd1;
					res_d.notify_pe = 1'b1;
					state_d         = ST_IDLE;
				end else begin
					res_d.start_phy = !ev_s1.receive_timeout;
					retries_d       = retries_q + 3'd1;
					state_d         = ST_TXDONE;
				end
			end
			default: ;
		endcase
		res_d.message_id = msg_id_d;
		// the stored receive id is reported as NO_ID in every result
		res_d.stored_rx_id = NO_ID;
		res_d.tx_state     = state_d;
	end

	// state registers, updated once per event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			retries_q <= 3'd0;
			msg_id_q  <= 3'd0;
		end else if (advance) begin
			state_q   <= state_d;
			retries_q <= retries_d;
			msg_id_q  <= msg_id_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(24 - RES_W)'(0), res_q};

	// success always comes with a policy engine notification
	a_sent_notifies: assert property (@(posedge clk) disable iff (!arst_n)
		res_d.message_sent |-> res_d.notify_pe)
		else $error("message_sent without notify_pe");

	// a phy layer reset leaves the id cleared and the block idle
	a_layer_reset_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_d.layer_reset) |=> (msg_id_q == 3'd0 && state_q == ST_IDLE))
		else $error("layer reset did not clear state");

	// txdone always moves on to the response wait
	a_txdone_to_resp: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && state_q == ST_TXDONE) |=> (state_q == ST_RESP))
		else $error("txdone phase did not move to response wait");

	// state only changes when an event is consumed
	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q) && $stable(msg_id_q) && $stable(retries_q))
		else $error("state changed without an event");

endmodule
